[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled every cycle outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mtf_pkg.sv]
// Shared types and codes for the move-to-front binding table.
package mtf_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 64;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  typedef struct packed {
    cmd_t               cmd;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } mtf_op_t;

endpackage

[hdl/mtf_if.sv]
// Request and response channel interfaces.
interface mtf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] key;
  logic [63:0] value_in;

  modport source (output valid, cmd, key, value_in, input ready);
  modport sink (input valid, cmd, key, value_in, output ready);
endinterface

interface mtf_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] value_out;
  logic [3:0]  hit_position;
  logic [4:0]  entry_count;

  modport source (output valid, status, value_out, hit_position, entry_count, input ready);
  modport sink (input valid, status, value_out, hit_position, entry_count, output ready);
endinterface

[hdl/move_to_front_binding_table_unit.sv]
// Top level of the move-to-front binding table.
// Path: a request passes the front-end queue, then the back-end response register.
// Throughput: one transaction per cycle while rsp.ready is high, set by the table's
// match-and-shift in the back end; a two-entry queue separates front and back.
// Reset (rst, synchronous): empties the table count, queue and response register;
// table contents are left as they were and never read before being written.
module move_to_front_binding_table_unit import mtf_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 32
) (
  input logic      clk,
  input logic      rst,
  mtf_req_if.sink  req,
  mtf_rsp_if.source rsp
);

  logic    op_valid;
  logic    op_ready;
  mtf_op_t op;

  mtf_front #(
    .KEY_BITS (KEY_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op)
  );

  mtf_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op),
    .rsp      (rsp)
  );

endmodule

[hdl/mtf_front.sv]
// Front end: accepts requests, decodes and masks them, and queues them.
module mtf_front import mtf_pkg::*; #(
  parameter int KEY_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  mtf_req_if.sink    req,
  output logic       op_valid,
  input  logic       op_ready,
  output mtf_op_t    op
);

  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KW);

  mtf_op_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  mtf_op_t    decoded;

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign op_valid  = (fill != 2'd0);
  assign pop       = op_valid && op_ready;
  assign op        = slots[rd_ptr];

  always_comb begin
    decoded.cmd   = cmd_t'(req.cmd);
    decoded.key   = req.key & KEY_MASK;
    decoded.value = req.value_in;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hdl/mtf_back.sv]
// Back end: binding table, parallel match, move-to-front shift, response register.
module mtf_back import mtf_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       op_valid,
  output logic       op_ready,
  input  mtf_op_t    op,
  mtf_rsp_if.source  rsp
);

  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int PW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [KW-1:0]      entry_keys   [TABLE_DEPTH];
  logic [VALUE_W-1:0] entry_values [TABLE_DEPTH];
  logic [CW-1:0]      used_count;
  logic [CW-1:0]      used_count_next;

  logic               out_valid;
  status_t            out_status;
  logic [VALUE_W-1:0] out_value;
  logic [POS_W-1:0]   out_pos;
  logic [COUNT_W-1:0] out_count;

  logic                   take;
  logic [TABLE_DEPTH-1:0] match;
  logic [TABLE_DEPTH-1:0] first;
  logic [TABLE_DEPTH-1:0] behind;
  logic [TABLE_DEPTH-1:0] shift_en;
  logic                   hit;
  logic [PW-1:0]          hit_pos;
  logic [VALUE_W-1:0]     hit_value;
  logic                   full;
  logic                   add_do;
  logic                   move_do;
  logic [VALUE_W-1:0]     front_value;
  status_t                status_next;
  logic [VALUE_W-1:0]     value_next;
  logic [PW+POS_W-1:0]    pos_ext;
  logic [CW+COUNT_W-1:0]  count_ext;

  assign op_ready = !out_valid || rsp.ready;
  assign take     = op_valid && op_ready;

  always_comb begin
    hit_pos   = '0;
    hit_value = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = (CW'(i) < used_count) && (entry_keys[i] == op.key[KW-1:0]);
    end
    first = match & (~match + TABLE_DEPTH'(1));
    hit   = |match;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (first[i]) begin
        hit_pos = hit_pos | PW'(i);
      end
      hit_value = hit_value | ({VALUE_W{first[i]}} & entry_values[i]);
      behind[i] = |(first & ({TABLE_DEPTH{1'b1}} << i));
    end
  end

  always_comb begin
    full            = (used_count == CW'(TABLE_DEPTH));
    add_do          = 1'b0;
    move_do         = 1'b0;
    used_count_next = used_count;
    status_next     = ST_OK;
    value_next      = '0;
    pos_ext         = '0;
    case (op.cmd)
      CMD_ADD: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          add_do          = 1'b1;
          used_count_next = used_count + CW'(1);
        end
      end
      CMD_LOOKUP: begin
        if (hit) begin
          move_do    = (hit_pos >= PW'(3));
          value_next = hit_value;
          pos_ext    = {{POS_W{1'b0}}, hit_pos};
        end else begin
          status_next = ST_MISS;
        end
      end
      CMD_CLEAR: begin
        used_count_next = '0;
      end
      default: begin
        used_count_next = used_count;
      end
    endcase
    count_ext   = {{COUNT_W{1'b0}}, used_count_next};
    front_value = add_do ? op.value : hit_value;
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      shift_en[j] = add_do || (move_do && behind[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (shift_en[0]) begin
        entry_keys[0]   <= op.key[KW-1:0];
        entry_values[0] <= front_value;
      end
      for (int j = 1; j < TABLE_DEPTH; j++) begin
        if (shift_en[j]) begin
          entry_keys[j]   <= entry_keys[j-1];
          entry_values[j] <= entry_values[j-1];
        end
      end
      out_status <= status_next;
      out_value  <= value_next;
      out_pos    <= pos_ext[POS_W-1:0];
      out_count  <= count_ext[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        used_count <= used_count_next;
        out_valid  <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.value_out    = out_value;
  assign rsp.hit_position = out_pos;
  assign rsp.entry_count  = out_count;

endmodule

[hdl/mtf_checker.sv]
// Port-level checker for the binding table and its bind statement.
`include "assert_macros.svh"

module mtf_checker import mtf_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  status,
  input logic [63:0] value_out,
  input logic [3:0]  hit_position,
  input logic [4:0]  entry_count
);

  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(value_out) && $stable(hit_position) && $stable(entry_count), "response changed while stalled")
  `ASSERT_IMPLIES(a_status_code, clk, rst, rsp_valid, status != 2'd3, "undefined status code")
  `ASSERT_IMPLIES(a_fail_zero, clk, rst, rsp_valid && (status == ST_MISS || status == ST_FULL), value_out == 64'd0 && hit_position == 4'd0, "failed operation returned data")
  `ASSERT_IMPLIES(a_full_count, clk, rst, rsp_valid && status == ST_FULL, entry_count == 5'(TABLE_DEPTH), "full refusal with table not full")

endmodule

bind move_to_front_binding_table_unit mtf_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_mtf_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .value_out    (rsp.value_out),
  .hit_position (rsp.hit_position),
  .entry_count  (rsp.entry_count)
);

[test/move_to_front_binding_table_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the move-to-front binding table unit.
module move_to_front_binding_table_unit_tb;
  import mtf_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS = 32;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] value_out;
    logic [POS_W-1:0]   hit_position;
    logic [COUNT_W-1:0] entry_count;
  } table_result_t;

  logic clk = 1'b0;
  logic rst;

  mtf_req_if req_ch ();
  mtf_rsp_if rsp_ch ();

  move_to_front_binding_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS(KEY_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the table, updated as each request transaction is accepted.
  logic [KEY_W-1:0]   table_keys   [TABLE_DEPTH];
  logic [VALUE_W-1:0] table_values [TABLE_DEPTH];
  int                 table_used;

  mtf_op_t       pending_ops [$];
  table_result_t expected_results [$];
  mtf_op_t       in_flight_op;
  int            send_idle;
  int            recv_stall;
  int            sent_count;
  int            recv_count;
  bit            send_quiet;
  bit            recv_quiet;
  int            error_count = 0;
  int            cycle_count = 0;

  function automatic table_result_t apply_binding_op(mtf_op_t op);
    table_result_t    r;
    int               hit;
    logic [KEY_W-1:0] hk;
    logic [VALUE_W-1:0] hv;
    r = '0;
    hit = -1;
    case (op.cmd)
      CMD_ADD: begin
        if (table_used >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = table_used; i > 0; i--) begin
            table_keys[i] = table_keys[i-1];
            table_values[i] = table_values[i-1];
          end
          table_keys[0] = op.key;
          table_values[0] = op.value;
          table_used++;
        end
      end
      CMD_LOOKUP: begin
        for (int i = 0; i < table_used; i++) begin
          if (hit < 0 && table_keys[i] == op.key) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          hk = table_keys[hit];
          hv = table_values[hit];
          r.value_out = hv;
          r.hit_position = hit[POS_W-1:0];
          // shallow hits keep their place
          if (hit >= 3) begin
            for (int i = hit; i > 0; i--) begin
              table_keys[i] = table_keys[i-1];
              table_values[i] = table_values[i-1];
            end
            table_keys[0] = hk;
            table_values[0] = hv;
          end
        end
      end
      CMD_CLEAR: table_used = 0;
      default: ;
    endcase
    r.entry_count = table_used[COUNT_W-1:0];
    return r;
  endfunction

  function automatic int draw_wait(bit quiet);
    if (quiet || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_idle <= 0;
      sent_count = 0;
      send_quiet = 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_results.push_back(apply_binding_op(in_flight_op));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_idle > 0) begin
          send_idle <= send_idle - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          in_flight_op = pending_ops.pop_front();
          req_ch.cmd <= in_flight_op.cmd;
          req_ch.key <= in_flight_op.key;
          req_ch.value_in <= in_flight_op.value;
          req_ch.valid <= 1'b1;
          if (sent_count % 40 == 0) send_quiet = ($urandom_range(0, 3) == 0);
          sent_count++;
          send_idle <= draw_wait(send_quiet);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    table_result_t exp_r;
    int            n;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_stall <= 0;
      recv_count = 0;
      recv_quiet = 1'b0;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected response transaction: status %0d", rsp_ch.status);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (rsp_ch.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, rsp_ch.status);
          error_count++;
        end
        if (rsp_ch.value_out !== exp_r.value_out) begin
          $error("value_out: expected %h, got %h", exp_r.value_out, rsp_ch.value_out);
          error_count++;
        end
        if (rsp_ch.hit_position !== exp_r.hit_position) begin
          $error("hit_position: expected %0d, got %0d", exp_r.hit_position,
                 rsp_ch.hit_position);
          error_count++;
        end
        if (rsp_ch.entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.entry_count,
                 rsp_ch.entry_count);
          error_count++;
        end
      end
      if (recv_count % 40 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
      recv_count++;
      n = draw_wait(recv_quiet);
      recv_stall <= n;
      rsp_ch.ready <= (n == 0);
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      rsp_ch.ready <= (recv_stall == 1);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("move_to_front_binding_table_unit_tb: FAIL");
      $finish;
    end
  end

  task automatic queue_op(cmd_t c, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
    mtf_op_t op;
    op.cmd = c;
    op.key = k;
    op.value = v;
    pending_ops.push_back(op);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_ops.size() != 0 || req_ch.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic queue_random_ops(int n_ops, int pool_size);
    logic [KEY_W-1:0] key_pool [$];
    int               counted;
    int               pick;
    mtf_op_t          op;
    counted = 0;
    repeat (pool_size) key_pool.push_back($urandom);
    while (counted < n_ops) begin
      pick = $urandom_range(0, 99);
      op.key = key_pool[$urandom_range(0, pool_size - 1)];
      if ($urandom_range(0, 19) == 0) op.key = $urandom;
      op.value = {$urandom, $urandom};
      if (pick < 45) op.cmd = CMD_ADD;
      else if (pick < 95) op.cmd = CMD_LOOKUP;
      else if (pick < 96) op.cmd = CMD_CLEAR;
      else op.cmd = CMD_NOP;
      pending_ops.push_back(op);
      if (op.cmd != CMD_NOP) counted++;
    end
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_NOP;
    req_ch.key = '0;
    req_ch.value_in = '0;
    rsp_ch.ready = 1'b0;
    table_used = 0;

    // directed: empty table, shadowing, fill to full, deep and shallow hits
    queue_op(CMD_LOOKUP, 32'h0000_0005, '0);
    queue_op(CMD_NOP, 32'hDEAD_BEEF, '1);
    queue_op(CMD_ADD, 32'h0000_0000, 64'h0);
    queue_op(CMD_ADD, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_op(CMD_ADD, 32'h0000_0000, 64'h1234);
    queue_op(CMD_LOOKUP, 32'h0000_0000, '0);
    for (int i = 0; i < 13; i++)
      queue_op(CMD_ADD, 32'h100 + i, {i[31:0], ~i[31:0]});
    queue_op(CMD_ADD, 32'h5555_AAAA, 64'hA5A5_A5A5_5A5A_5A5A);
    queue_op(CMD_LOOKUP, 32'hFFFF_FFFF, '0);
    queue_op(CMD_LOOKUP, 32'h10B, '0);
    queue_op(CMD_LOOKUP, 32'h10A, '0);
    queue_op(CMD_LOOKUP, 32'h0000_0000, '0);
    queue_op(CMD_LOOKUP, 32'h0BAD_0000, '0);
    queue_op(CMD_CLEAR, 32'h0, '0);
    queue_op(CMD_LOOKUP, 32'h0000_0000, '0);
    queue_op(CMD_ADD, 32'h8000_0001, 64'h8000_0000_0000_0001);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // sender holds off until the table has answered everything
    wait_drained();
    queue_random_ops(250, 24);
    wait_drained();
    queue_random_ops(250, 6);
    wait_drained();
    queue_random_ops(250, 40);
    wait_drained();
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("move_to_front_binding_table_unit_tb: PASS");
    end else begin
      $display("move_to_front_binding_table_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/mtf_pkg.sv
hdl/mtf_if.sv
hdl/mtf_front.sv
hdl/mtf_back.sv
hdl/move_to_front_binding_table_unit.sv
hdl/mtf_checker.sv
test/move_to_front_binding_table_unit_tb.sv
